// ----- design/gas_pkg.sv -----
`default_nettype none

package gas_pkg;

  localparam int POS_W    = 32;
  localparam int MASS_W   = 32;
  localparam int GC_W     = 32;
  localparam int MAG_W    = POS_W + 1;
  localparam int ACC_W    = 48;
  localparam int IN_W     = 6 * POS_W + MASS_W;
  localparam int OUT_W    = 3 * ACC_W;
  localparam int ROOT_W   = 50;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int REM_W    = ROOT_W + 4;
  localparam int MB_W     = ROOT_W;
  localparam int MA_W     = 3 * ROOT_W;
  localparam int GM_W     = GC_W + MASS_W;
  localparam int NUM_SH   = 40;
  localparam int NUM_W    = GM_W + MAG_W + NUM_SH;
  localparam int Q_W      = 57;
  localparam int DEN_W    = MA_W + Q_W - 1;
  localparam int SUM_W    = Q_W + 2;
  localparam int CNT_W    = 6;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = Q_W;

  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Z = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQ_LD, ST_SQ_RUN, ST_SQRT_LD, ST_SQRT_RUN, ST_R2_LD, ST_R2_RUN,
    ST_R3_LD, ST_R3_RUN, ST_GM_LD, ST_GM_RUN, ST_NUM_LD, ST_NUM_RUN,
    ST_DIV_LD, ST_DIV_RUN, ST_ACC, ST_END, ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD_IN, OP_SQ_LD, OP_MUL_STEP, OP_SQRT_LD, OP_SQRT_STEP,
    OP_R2_LD, OP_R3_LD, OP_GM_LD, OP_NUM_LD, OP_DIV_LD, OP_DIV_STEP,
    OP_ACC, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t   op;
    axis_t axis;
  } dp_cmd_t;

  typedef struct packed {
    logic mb_zero;
    logic s_zero;
    logic last;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- design/gravity_acceleration_sum.sv -----
// channel | dir | beat contents
// in_     | in  | tdata: self_x, self_y, self_z, other_x, other_y, other_z, other_mass;
//         |     | tlast: last_body
// out_    | out | tdata: acc_x, acc_y, acc_z; tuser: saturated
// cfg_    | in  | apb register grav_const at byte address 0
//
// one beat at a time: the time per beat is set by the shift-add
// multiplier (one multiplier bit per cycle), 50 square root and 57 divide steps
// a beat with |d| = 0 skips the root, the divide and the sums, and adds nothing
// synchronous active-low reset clears the sums, the state machine and the output valid
// a stalled result holds in the output register while the next beat is taken

`default_nettype none

module gravity_acceleration_sum (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // self_x, self_y, self_z, other_x, other_y, other_z, other_mass
  input  wire logic [gas_pkg::IN_W-1:0]     in_tdata,
  input  wire logic                         in_tlast,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // acc_x, acc_y, acc_z
  output logic [gas_pkg::OUT_W-1:0]         out_tdata,
  // saturated
  output logic                              out_tuser,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [2:0]                   cfg_paddr,
  input  wire logic [31:0]                  cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import gas_pkg::*;

  logic [GC_W-1:0] grav_const_r;
  dp_cmd_t         cmd;
  dp_stat_t        stat;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_const_r <= GC_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
      grav_const_r <= cfg_pwdata;
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : grav_const_r;

  gas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  gas_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .grav_const (grav_const_r),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// ----- design/gas_datapath.sv -----
`default_nettype none

module gas_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire gas_pkg::dp_cmd_t          cmd,
  output gas_pkg::dp_stat_t              stat,
  input  wire logic [gas_pkg::GC_W-1:0]  grav_const,
  input  wire logic [gas_pkg::IN_W-1:0]  in_tdata,
  input  wire logic                      in_tlast,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [gas_pkg::OUT_W-1:0]      out_tdata,
  output logic                           out_tuser
);
  import gas_pkg::*;

  logic [MAG_W-1:0]  mag_r [3];
  logic              neg_r [3];
  logic              last_r;
  logic [MASS_W-1:0] mass_r;
  logic [MA_W-1:0]   ma_r;
  logic [MB_W-1:0]   mb_r;
  logic [MA_W-1:0]   prod_r;
  logic [MA_W-1:0]   rq3_r;
  logic [GM_W-1:0]   gm_r;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [NUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  dsh_r;
  logic [Q_W-1:0]    q_r;
  logic [ACC_W-1:0]  sum_r [3];
  logic              sat_r;
  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;
  logic              out_sat_r;

  logic [MAG_W-1:0]  d      [3];
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              sq_ge;
  logic              div_ge;
  logic [GM_W-1:0]   gm_sel;
  logic [Q_W-1:0]    qm;
  logic [SUM_W-1:0]  term_pos;
  logic [SUM_W-1:0]  term;
  logic [SUM_W-1:0]  tot;
  logic              in_range;
  logic [ACC_W-1:0]  sum_new;

  // per-axis difference self minus other, sign-extended
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i] = {in_tdata[i*POS_W + POS_W - 1], in_tdata[i*POS_W +: POS_W]}
           - {in_tdata[(i+3)*POS_W + POS_W - 1], in_tdata[(i+3)*POS_W +: POS_W]};
    end
  end

  assign rem_sh  = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial   = REM_W'({root_r, 2'b01});
  assign sq_ge   = rem_sh >= trial;
  assign div_ge  = dsh_r <= DEN_W'(num_r);
  assign gm_sel  = (cmd.axis == AXIS_X) ? prod_r[GM_W-1:0] : gm_r;

  // quotient at or above 2^56 is clamped
  assign qm       = q_r[Q_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : q_r;
  assign term_pos = SUM_W'(qm);
  assign term     = neg_r[cmd.axis] ? term_pos : -term_pos;
  assign tot      = {{(SUM_W-ACC_W){sum_r[cmd.axis][ACC_W-1]}}, sum_r[cmd.axis]} + term;
  assign in_range = (tot[SUM_W-1:ACC_W-1] == '0) || (tot[SUM_W-1:ACC_W-1] == '1);
  assign sum_new  = in_range ? tot[ACC_W-1:0]
                  : (tot[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}});

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD_IN: begin
        for (int i = 0; i < 3; i++) begin
          mag_r[i] <= d[i][MAG_W-1] ? -d[i] : d[i];
          neg_r[i] <= d[i][MAG_W-1];
        end
        mass_r <= in_tdata[6*POS_W +: MASS_W];
        last_r <= in_tlast;
      end
      OP_SQ_LD: begin
        ma_r <= MA_W'(mag_r[cmd.axis]);
        mb_r <= MB_W'(mag_r[cmd.axis]);
        if (cmd.axis == AXIS_X) begin
          prod_r <= '0;
        end
      end
      OP_MUL_STEP: begin
        if (mb_r[0]) begin
          prod_r <= prod_r + ma_r;
        end
        ma_r <= {ma_r[MA_W-2:0], 1'b0};
        mb_r <= {1'b0, mb_r[MB_W-1:1]};
      end
      OP_SQRT_LD: begin
        rad_r  <= {prod_r[RAD_W-33:0], 32'd0};
        rem_r  <= '0;
        root_r <= '0;
      end
      OP_SQRT_STEP: begin
        rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
        rem_r  <= sq_ge ? rem_sh - trial : rem_sh;
        root_r <= {root_r[ROOT_W-2:0], sq_ge};
      end
      OP_R2_LD: begin
        ma_r   <= MA_W'(root_r);
        mb_r   <= root_r;
        prod_r <= '0;
      end
      OP_R3_LD: begin
        ma_r   <= prod_r;
        mb_r   <= root_r;
        prod_r <= '0;
      end
      OP_GM_LD: begin
        rq3_r  <= prod_r;
        ma_r   <= MA_W'(grav_const);
        mb_r   <= MB_W'(mass_r);
        prod_r <= '0;
      end
      OP_NUM_LD: begin
        gm_r   <= gm_sel;
        ma_r   <= MA_W'(gm_sel);
        mb_r   <= MB_W'(mag_r[cmd.axis]);
        prod_r <= '0;
      end
      OP_DIV_LD: begin
        num_r <= {prod_r[NUM_W-NUM_SH-1:0], {NUM_SH{1'b0}}};
        dsh_r <= {rq3_r, {(Q_W-1){1'b0}}};
        q_r   <= '0;
      end
      OP_DIV_STEP: begin
        if (div_ge) begin
          num_r <= num_r - dsh_r[NUM_W-1:0];
        end
        q_r   <= {q_r[Q_W-2:0], div_ge};
        dsh_r <= {1'b0, dsh_r[DEN_W-1:1]};
      end
      OP_EMIT: begin
        out_data_r <= {sum_r[2], sum_r[1], sum_r[0]};
        out_sat_r  <= sat_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= '0;
      end
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_ACC: begin
          sum_r[cmd.axis] <= sum_new;
          if (!in_range) begin
            sat_r <= 1'b1;
          end
        end
        OP_EMIT: begin
          for (int i = 0; i < 3; i++) begin
            sum_r[i] <= '0;
          end
          sat_r       <= 1'b0;
          out_valid_r <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat.mb_zero  = (mb_r == '0);
  assign stat.s_zero   = (prod_r == '0);
  assign stat.last     = last_r;
  assign stat.out_busy = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

endmodule

`default_nettype wire

// ----- design/gas_ctrl.sv -----
`default_nettype none

module gas_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output gas_pkg::dp_cmd_t       cmd,
  input  wire gas_pkg::dp_stat_t stat
);
  import gas_pkg::*;

  state_t           state_r, state_nxt;
  axis_t            axis_r, axis_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      axis_r  <= AXIS_X;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_SQ_LD;
          axis_nxt  = AXIS_X;
        end
      end
      ST_SQ_LD:   state_nxt = ST_SQ_RUN;
      ST_SQ_RUN: begin
        if (stat.mb_zero) begin
          if (axis_r != AXIS_Z) begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = ST_SQ_LD;
          end else if (stat.s_zero) begin
            state_nxt = ST_END;
          end else begin
            state_nxt = ST_SQRT_LD;
          end
        end
      end
      ST_SQRT_LD: begin
        cnt_nxt   = '0;
        state_nxt = ST_SQRT_RUN;
      end
      ST_SQRT_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          state_nxt = ST_R2_LD;
        end
      end
      ST_R2_LD:   state_nxt = ST_R2_RUN;
      ST_R2_RUN:  if (stat.mb_zero) state_nxt = ST_R3_LD;
      ST_R3_LD:   state_nxt = ST_R3_RUN;
      ST_R3_RUN:  if (stat.mb_zero) state_nxt = ST_GM_LD;
      ST_GM_LD: begin
        axis_nxt  = AXIS_X;
        state_nxt = ST_GM_RUN;
      end
      ST_GM_RUN:  if (stat.mb_zero) state_nxt = ST_NUM_LD;
      ST_NUM_LD:  state_nxt = ST_NUM_RUN;
      ST_NUM_RUN: if (stat.mb_zero) state_nxt = ST_DIV_LD;
      ST_DIV_LD: begin
        cnt_nxt   = '0;
        state_nxt = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (axis_r == AXIS_Z) begin
          state_nxt = ST_END;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_NUM_LD;
        end
      end
      ST_END:     state_nxt = stat.last ? ST_EMIT : ST_IDLE;
      ST_EMIT:    if (!stat.out_busy) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.axis  = axis_r;
    cmd.op    = OP_NONE;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = OP_LOAD_IN;
        end
      end
      ST_SQ_LD:    cmd.op = OP_SQ_LD;
      ST_SQ_RUN:   cmd.op = OP_MUL_STEP;
      ST_SQRT_LD:  cmd.op = OP_SQRT_LD;
      ST_SQRT_RUN: cmd.op = OP_SQRT_STEP;
      ST_R2_LD:    cmd.op = OP_R2_LD;
      ST_R2_RUN:   cmd.op = OP_MUL_STEP;
      ST_R3_LD:    cmd.op = OP_R3_LD;
      ST_R3_RUN:   cmd.op = OP_MUL_STEP;
      ST_GM_LD:    cmd.op = OP_GM_LD;
      ST_GM_RUN:   cmd.op = OP_MUL_STEP;
      ST_NUM_LD:   cmd.op = OP_NUM_LD;
      ST_NUM_RUN:  cmd.op = OP_MUL_STEP;
      ST_DIV_LD:   cmd.op = OP_DIV_LD;
      ST_DIV_RUN:  cmd.op = OP_DIV_STEP;
      ST_ACC:      cmd.op = OP_ACC;
      ST_EMIT:     cmd.op = stat.out_busy ? OP_NONE : OP_EMIT;
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/gas_checker.sv -----
`default_nettype none

module gas_checker (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_tvalid,
  input wire logic                     in_tready,
  input wire logic                     out_tvalid,
  input wire logic                     out_tready,
  input wire logic [gas_pkg::OUT_W-1:0] out_tdata
);

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken while busy");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result without work in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

endmodule

bind gravity_acceleration_sum gas_checker u_gas_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
